FILE: src/mrsr_pkg.sv
package mrsr_pkg;

    // Default sizes of the coil, input and register spaces.
    localparam int NUM_COILS_DEF   = 64;
    localparam int NUM_DINPUTS_DEF = 64;
    localparam int NUM_HREGS_DEF   = 16;
    localparam int NUM_IREGS_DEF   = 16;

    // Fixed widths of the item fields.
    localparam int BIT_W     = 64;
    localparam int TAB_DEPTH = 16;
    localparam int TIDX_W    = 4;
    localparam int LEN_W     = 6;
    localparam int IN_W      = 136;
    localparam int OUT_W     = 72;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] OP_REQUEST   = 2'd0;
    localparam logic [1:0] OP_LOAD_IREG = 2'd1;
    localparam logic [1:0] OP_LOAD_HREG = 2'd2;
    localparam logic [1:0] OP_IGNORED   = 2'd3;

    // Modbus function codes.
    localparam logic [7:0] FC_READ_COILS   = 8'd1;
    localparam logic [7:0] FC_READ_DINPUTS = 8'd2;
    localparam logic [7:0] FC_READ_HREGS   = 8'd3;
    localparam logic [7:0] FC_READ_IREGS   = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL   = 8'd5;

    // Exception and value constants.
    localparam logic [7:0]  EXC_FLAG    = 8'h80;
    localparam logic [7:0]  EXC_VALUE   = 8'd3;
    localparam logic [7:0]  EXC_ADDRESS = 8'd2;
    localparam logic [15:0] LIMIT_BITS  = 16'h07D0;
    localparam logic [15:0] LIMIT_REGS  = 16'h007D;
    localparam logic [15:0] COIL_ON     = 16'hFF00;
    localparam logic [15:0] COIL_OFF    = 16'h0000;
    localparam logic [15:0] QTY_MIN     = 16'h0001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COIL_BASE   = 2'd0;
    localparam logic [1:0] CFG_DINPUT_BASE = 2'd1;
    localparam logic [1:0] CFG_HREG_BASE   = 2'd2;
    localparam logic [1:0] CFG_IREG_BASE   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RK_NONE,
        RK_EXC,
        RK_BITS,
        RK_REGS,
        RK_WRITE
    } resp_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic check;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic respond;
        logic out_free;
        logic final_byte;
    } sts_t;

    // One byte through the CRC-16/MODBUS, reflected.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: src/mrsr_ctrl.sv
module mrsr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic [1:0]         opcode,
    output logic               s_tready,
    output mrsr_pkg::cmd_t     cmd,
    input  mrsr_pkg::sts_t     sts
);
    import mrsr_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && opcode == OP_REQUEST)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                state_next = sts.respond ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.final_byte)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The check state follows in the next cycle after a request item is taken.
    a_check_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && opcode == OP_REQUEST) |=> state_reg == ST_CHECK)
        else $error("request not checked");
    // Only the idle state takes items.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !cmd.accept && !cmd.check)
        else $error("item taken while responding");
    // Leaving emission needs the final byte.
    a_leave_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |-> sts.final_byte && cmd.emit)
        else $error("response cut short");

endmodule

FILE: src/mrsr_dp.sv
module mrsr_dp #(
    parameter int NUM_COILS   = mrsr_pkg::NUM_COILS_DEF,
    parameter int NUM_DINPUTS = mrsr_pkg::NUM_DINPUTS_DEF,
    parameter int NUM_HREGS   = mrsr_pkg::NUM_HREGS_DEF,
    parameter int NUM_IREGS   = mrsr_pkg::NUM_IREGS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    opcode,
    input  logic [mrsr_pkg::IN_W-1:0]     in_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  mrsr_pkg::cmd_t                cmd,
    output mrsr_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mrsr_pkg::OUT_W-1:0]    out_data,
    output logic                          out_last
);
    import mrsr_pkg::*;

    // Configuration registers.
    logic [15:0] coil_base_reg, dinput_base_reg, hreg_base_reg, ireg_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_base_reg   <= '0;
            dinput_base_reg <= '0;
            hreg_base_reg   <= '0;
            ireg_base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COIL_BASE:   coil_base_reg   <= cfg_data;
                CFG_DINPUT_BASE: dinput_base_reg <= cfg_data;
                CFG_HREG_BASE:   hreg_base_reg   <= cfg_data;
                CFG_IREG_BASE:   ireg_base_reg   <= cfg_data;
                default:         coil_base_reg   <= coil_base_reg;
            endcase
        end
    end

    // Fields of the input item.
    logic [7:0]        in_unit, in_fc;
    logic [15:0]       in_start, in_qv, in_tval;
    logic [BIT_W-1:0]  in_dins;
    logic [TIDX_W-1:0] in_tidx;

    assign in_unit  = in_data[7:0];
    assign in_fc    = in_data[15:8];
    assign in_start = in_data[31:16];
    assign in_qv    = in_data[47:32];
    assign in_dins  = in_data[111:48];
    assign in_tidx  = in_data[115:112];
    assign in_tval  = in_data[131:116];

    // Register tables, written by load items.
    logic [15:0] hold_tab [TAB_DEPTH];
    logic [15:0] inp_tab  [TAB_DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.accept && opcode == OP_LOAD_HREG)
            hold_tab[in_tidx] <= in_tval;
        if (cmd.accept && opcode == OP_LOAD_IREG)
            inp_tab[in_tidx] <= in_tval;
    end

    // Captured request.
    logic [7:0]       unit_reg, fc_reg;
    logic [15:0]      start_reg, qv_reg;
    logic [BIT_W-1:0] dins_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            unit_reg  <= in_unit;
            fc_reg    <= in_fc;
            start_reg <= in_start;
            qv_reg    <= in_qv;
            dins_reg  <= in_dins;
        end
    end

    // Request check: value checks first, then address checks.
    logic [15:0]      base, limit, first;
    logic [17:0]      n18, s18, q18, b18, end18;
    logic             val_ok, addr_ok, wval_ok, waddr_ok;
    resp_kind_t       chk_kind;
    logic [7:0]       chk_code, chk_cnt;
    logic [LEN_W-1:0] chk_len;
    logic [7:0]       bcount;

    always_comb
    begin
        base  = coil_base_reg;
        n18   = 18'(NUM_COILS);
        limit = LIMIT_BITS;
        unique case (fc_reg)
            FC_READ_DINPUTS:
            begin
                base = dinput_base_reg;
                n18  = 18'(NUM_DINPUTS);
            end
            FC_READ_HREGS:
            begin
                base  = hreg_base_reg;
                n18   = 18'(NUM_HREGS);
                limit = LIMIT_REGS;
            end
            FC_READ_IREGS:
            begin
                base  = ireg_base_reg;
                n18   = 18'(NUM_IREGS);
                limit = LIMIT_REGS;
            end
            default:
            begin
                base = coil_base_reg;
            end
        endcase
        s18      = {2'b00, start_reg};
        q18      = {2'b00, qv_reg};
        b18      = {2'b00, base};
        end18    = b18 + n18;
        val_ok   = qv_reg >= QTY_MIN && qv_reg <= limit && (s18 + q18 <= end18);
        addr_ok  = s18 >= b18 && (s18 + q18 - 18'd1 < end18);
        wval_ok  = qv_reg == COIL_OFF || qv_reg == COIL_ON;
        waddr_ok = s18 >= b18 && s18 < end18;
        first    = start_reg - base;
        bcount   = 8'((qv_reg[6:0] + 7'd7) >> 3);

        chk_kind = RK_NONE;
        chk_code = EXC_VALUE;
        chk_cnt  = 8'h00;
        chk_len  = LEN_W'(3);
        priority case (fc_reg)
            FC_READ_COILS, FC_READ_DINPUTS, FC_READ_HREGS, FC_READ_IREGS:
            begin
                if (!val_ok)
                    chk_kind = RK_EXC;
                else if (!addr_ok)
                begin
                    chk_kind = RK_EXC;
                    chk_code = EXC_ADDRESS;
                end
                else if (fc_reg == FC_READ_COILS || fc_reg == FC_READ_DINPUTS)
                begin
                    chk_kind = RK_BITS;
                    chk_cnt  = bcount;
                    chk_len  = LEN_W'(bcount + 8'd3);
                end
                else
                begin
                    chk_kind = RK_REGS;
                    chk_cnt  = {qv_reg[6:0], 1'b0};
                    chk_len  = LEN_W'({qv_reg[6:0], 1'b0} + 8'd3);
                end
            end
            FC_WRITE_COIL:
            begin
                if (!wval_ok)
                    chk_kind = RK_EXC;
                else if (!waddr_ok)
                begin
                    chk_kind = RK_EXC;
                    chk_code = EXC_ADDRESS;
                end
                else
                begin
                    chk_kind = RK_WRITE;
                    chk_len  = LEN_W'(6);
                end
            end
            default:
            begin
                chk_kind = RK_NONE;
            end
        endcase
    end

    // Bit source rotated so that the first addressed bit sits at bit 0.
    logic [BIT_W-1:0]   coil_reg;
    logic [BIT_W-1:0]   bit_src;
    logic [2*BIT_W-1:0] bit_dbl;

    assign bit_src = (fc_reg == FC_READ_COILS) ? coil_reg : dins_reg;
    assign bit_dbl = {bit_src, bit_src} >> first[5:0];

    // Response state set up by the check.
    resp_kind_t        kind_reg;
    logic [7:0]        code_reg, cnt_reg;
    logic [LEN_W-1:0]  len_reg, k_reg;
    logic [BIT_W-1:0]  rot_reg;
    logic [TIDX_W-1:0] first_reg;
    logic [6:0]        qty_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        cur_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg <= '0;
            k_reg    <= '0;
            len_reg  <= '0;
        end
        else if (cmd.check)
        begin
            k_reg   <= '0;
            len_reg <= chk_len;
            if (chk_kind == RK_WRITE)
                coil_reg[first[5:0]] <= (qv_reg == COIL_ON);
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            kind_reg  <= chk_kind;
            code_reg  <= chk_code;
            cnt_reg   <= chk_cnt;
            rot_reg   <= bit_dbl[BIT_W-1:0];
            first_reg <= first[TIDX_W-1:0];
            qty_reg   <= qv_reg[6:0];
            crc_reg   <= CRC_INIT;
        end
        else if (cmd.emit && k_reg < len_reg)
        begin
            crc_reg <= crc16_byte(crc_reg, cur_byte);
        end
    end

    // Byte for the current position of the frame.
    logic [7:0]        bit_byte, reg_hi, reg_lo;
    logic [LEN_W-1:0]  r;
    logic [TIDX_W-1:0] ridx;
    logic [15:0]       rword;
    logic [6:0]        bpos;

    always_comb
    begin
        r     = k_reg - LEN_W'(3);
        ridx  = first_reg + TIDX_W'(r[LEN_W-1:1]);
        rword = (fc_reg == FC_READ_HREGS) ? hold_tab[ridx] : inp_tab[ridx];
        reg_hi = rword[15:8];
        reg_lo = rword[7:0];
        for (int b = 0; b < 8; b++)
        begin
            bpos = {r[3:0], 3'(b)};
            bit_byte[b] = (bpos < qty_reg) ? rot_reg[{r[2:0], 3'(b)}] : 1'b0;
        end

        cur_byte = unit_reg;
        priority if (k_reg == len_reg)
            cur_byte = crc_reg[7:0];
        else if (k_reg == len_reg + LEN_W'(1))
            cur_byte = crc_reg[15:8];
        else if (k_reg == LEN_W'(0))
            cur_byte = unit_reg;
        else if (k_reg == LEN_W'(1))
            cur_byte = (kind_reg == RK_EXC) ? (fc_reg | EXC_FLAG) : fc_reg;
        else
        begin
            unique case (kind_reg)
                RK_EXC:   cur_byte = code_reg;
                RK_WRITE:
                begin
                    unique case (k_reg[1:0])
                        2'd2:    cur_byte = start_reg[15:8];
                        2'd3:    cur_byte = start_reg[7:0];
                        2'd0:    cur_byte = qv_reg[15:8];
                        default: cur_byte = qv_reg[7:0];
                    endcase
                end
                RK_BITS:  cur_byte = (k_reg == LEN_W'(2)) ? cnt_reg : bit_byte;
                RK_REGS:
                begin
                    if (k_reg == LEN_W'(2))
                        cur_byte = cnt_reg;
                    else
                        cur_byte = r[0] ? reg_lo : reg_hi;
                end
                default:  cur_byte = unit_reg;
            endcase
        end
    end

    // Output register.
    logic             out_valid_reg, out_last_reg;
    logic [OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {coil_reg, cur_byte};
            out_last_reg <= (k_reg == len_reg + LEN_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // Status to the controller.
    assign sts.respond    = (chk_kind != RK_NONE) && (unit_reg != 8'h00);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.final_byte = (k_reg == len_reg + LEN_W'(1));

    // A byte is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("output overwritten");
    // Coil state changes only on a checked write.
    a_coil_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.check |=> $stable(coil_reg))
        else $error("coil bits changed outside a write");
    // The byte position never runs past the CRC bytes.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= len_reg + LEN_W'(2))
        else $error("frame position overrun");

endmodule

FILE: src/modbus_rtu_slave_responder_top.sv
// Modbus RTU slave responder. Each input item is a decoded request (function
// codes 1 to 5) or a load of one input or holding register entry; a request
// is answered as a stream of response bytes ending in the CRC-16, low byte
// first, with tlast on the final byte. Broadcast requests and unknown
// function codes give no bytes. Items of the ignored opcode are taken and
// dropped. A request is accepted, then goes through the address and value
// checks, then its response bytes are sent; the byte sequencer emits one
// byte per cycle while the sink does not stall, and the next item is taken
// once the last byte has entered the output register. Register entries read
// before they are loaded return unspecified data.
module modbus_rtu_slave_responder_top #(
    parameter int NUM_COILS   = mrsr_pkg::NUM_COILS_DEF,
    parameter int NUM_DINPUTS = mrsr_pkg::NUM_DINPUTS_DEF,
    parameter int NUM_HREGS   = mrsr_pkg::NUM_HREGS_DEF,
    parameter int NUM_IREGS   = mrsr_pkg::NUM_IREGS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // unit_id, function_code, starting address, quantity_or_value,
    // discrete_inputs, table_index, table_value, zero fill
    input  logic [mrsr_pkg::IN_W-1:0]     s_tdata,
    // opcode
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // resp_byte, coil_levels
    output logic [mrsr_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import mrsr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mrsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mrsr_dp #(
        .NUM_COILS   (NUM_COILS),
        .NUM_DINPUTS (NUM_DINPUTS),
        .NUM_HREGS   (NUM_HREGS),
        .NUM_IREGS   (NUM_IREGS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: test/testbench.sv
module testbench;
    import mrsr_pkg::*;

    // One expected response byte with the coil levels that travel beside it.
    typedef struct {
        logic [7:0]  resp_byte;
        logic        last;
        logic [63:0] coil_levels;
    } resp_beat_t;

    // Predicts the response bytes of the responder and holds them until they arrive.
    class modbus_scoreboard;
        logic [63:0] coil_bits;
        logic [15:0] hold_regs [16];
        logic [15:0] input_regs [16];
        int          bases [4];
        resp_beat_t  beats_q [$];

        function new();
            coil_bits = '0;
            foreach (bases[i])
                bases[i] = 0;
        endfunction

        function void set_base(logic [1:0] idx, logic [15:0] value);
            bases[idx] = int'(value);
        endfunction

        // Value checks come before address checks; sums are taken without wrapping.
        function logic [7:0] read_error(int start, int qty, int base, int n, int limit);
            if (!(qty >= int'(QTY_MIN) && qty <= limit && qty <= base + n - start))
                return EXC_VALUE;
            if (!(start >= base && start + qty - 1 < base + n))
                return EXC_ADDRESS;
            return 8'd0;
        endfunction

        // Notes one accepted input item and queues the response bytes it causes.
        function void note_item(logic [1:0] op, logic [7:0] unit_id, logic [7:0] fc,
                                logic [15:0] req_addr, logic [15:0] qv,
                                logic [63:0] dins, logic [3:0] tidx, logic [15:0] tval);
            logic [7:0]  frame [$];
            logic [7:0]  err;
            logic [63:0] src;
            logic [15:0] crc;
            logic [15:0] word;
            int          start;
            int          qty;
            int          base;
            int          n;
            int          first;
            int          idx;
            resp_beat_t  beat;
            start = int'(req_addr);
            qty = int'(qv);
            if (op == OP_LOAD_IREG)
            begin
                input_regs[tidx] = tval;
                return;
            end
            if (op == OP_LOAD_HREG)
            begin
                hold_regs[tidx] = tval;
                return;
            end
            if (op != OP_REQUEST)
                return;
            case (fc)
                FC_READ_COILS, FC_READ_DINPUTS:
                begin
                    base = (fc == FC_READ_COILS) ? bases[CFG_COIL_BASE] : bases[CFG_DINPUT_BASE];
                    n = (fc == FC_READ_COILS) ? NUM_COILS_DEF : NUM_DINPUTS_DEF;
                    src = (fc == FC_READ_COILS) ? coil_bits : dins;
                    err = read_error(start, qty, base, n, int'(LIMIT_BITS));
                    if (err != 0)
                        frame = '{unit_id, fc | EXC_FLAG, err};
                    else
                    begin
                        first = start - base;
                        frame = '{unit_id, fc, 8'((qty + 7) / 8)};
                        for (int i = 0; i < (qty + 7) / 8; i++)
                            frame.push_back(8'h00);
                        for (int i = 0; i < qty; i++)
                        begin
                            idx = (first + i) & 63;
                            if (src[idx])
                                frame[3 + i / 8] = frame[3 + i / 8] | 8'(1 << (i % 8));
                        end
                    end
                end
                FC_READ_HREGS, FC_READ_IREGS:
                begin
                    base = (fc == FC_READ_HREGS) ? bases[CFG_HREG_BASE] : bases[CFG_IREG_BASE];
                    n = (fc == FC_READ_HREGS) ? NUM_HREGS_DEF : NUM_IREGS_DEF;
                    err = read_error(start, qty, base, n, int'(LIMIT_REGS));
                    if (err != 0)
                        frame = '{unit_id, fc | EXC_FLAG, err};
                    else
                    begin
                        first = start - base;
                        frame = '{unit_id, fc, 8'(qty * 2)};
                        for (int i = 0; i < qty; i++)
                        begin
                            idx = (first + i) & 15;
                            word = (fc == FC_READ_HREGS) ? hold_regs[idx] : input_regs[idx];
                            frame.push_back(word[15:8]);
                            frame.push_back(word[7:0]);
                        end
                    end
                end
                FC_WRITE_COIL:
                begin
                    base = bases[CFG_COIL_BASE];
                    if (!(qv == COIL_OFF || qv == COIL_ON))
                        frame = '{unit_id, fc | EXC_FLAG, EXC_VALUE};
                    else if (!(start >= base && start < base + NUM_COILS_DEF))
                        frame = '{unit_id, fc | EXC_FLAG, EXC_ADDRESS};
                    else
                    begin
                        idx = (start - base) & 63;
                        coil_bits[idx] = (qv == COIL_ON);
                        frame = '{unit_id, fc, req_addr[15:8], req_addr[7:0],
                                  qv[15:8], qv[7:0]};
                    end
                end
                default:
                    ;
            endcase
            // Broadcast and unknown codes give no bytes.
            if (unit_id == 8'd0 || frame.size() == 0)
                return;
            crc = CRC_INIT;
            foreach (frame[i])
            begin
                crc = crc ^ {8'h00, frame[i]};
                for (int k = 0; k < 8; k++)
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
            foreach (frame[i])
            begin
                beat.resp_byte = frame[i];
                beat.last = (i == frame.size() - 1);
                beat.coil_levels = coil_bits;
                beats_q.push_back(beat);
            end
        endfunction

        // Compares one output item with the oldest expected byte; empty string when it matches.
        function string check_result(logic [7:0] resp_byte, logic last, logic [63:0] levels);
            resp_beat_t exp_beat;
            if (beats_q.size() == 0)
                return $sformatf("unexpected byte %02h", resp_byte);
            exp_beat = beats_q.pop_front();
            if (resp_byte !== exp_beat.resp_byte)
                return $sformatf("byte %02h, expected %02h", resp_byte, exp_beat.resp_byte);
            if (last !== exp_beat.last)
                return $sformatf("tlast %0b, expected %0b", last, exp_beat.last);
            if (levels !== exp_beat.coil_levels)
                return $sformatf("coils %016h, expected %016h", levels, exp_beat.coil_levels);
            return "";
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tlast;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    modbus_scoreboard   resp_sb;
    int                 mismatches;
    int                 burst_left;
    int                 stall_mode;
    int                 stall_count;

    modbus_rtu_slave_responder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Receiver stalls follow a randomly drawn mode: always ready, random, a short ready window, or mostly ready.
    always @(posedge clk)
    begin
        stall_count <= stall_count + 1;
        if (stall_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ((stall_count % 16) < 3);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Output items are sampled on the falling edge before the rising edge that takes them.
    always @(negedge clk)
    begin
        string msg;
        if (rst_n && m_tvalid && m_tready)
        begin
            msg = resp_sb.check_result(m_tdata[7:0], m_tlast, m_tdata[71:8]);
            if (msg != "")
                report(msg);
        end
    end

    // Sends one item; the sender works in bursts separated by random gaps.
    task automatic send_item(logic [1:0] op, logic [7:0] unit_id, logic [7:0] fc,
                             logic [15:0] req_addr, logic [15:0] qv, logic [63:0] dins,
                             logic [3:0] tidx, logic [15:0] tval);
        int gap;
        s_tdata <= {4'h0, tval, tidx, dins, qv, req_addr, fc, unit_id};
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        resp_sb.note_item(op, unit_id, fc, req_addr, qv, dins, tidx, tval);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_request(logic [7:0] unit_id, logic [7:0] fc,
                                logic [15:0] req_addr, logic [15:0] qv, logic [63:0] dins);
        send_item(OP_REQUEST, unit_id, fc, req_addr, qv, dins,
                  4'($urandom), 16'($urandom));
    endtask

    // Holds the sender until every expected byte has come and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (resp_sb.beats_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        resp_sb.set_base(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed requests near the configured windows, the rest noise.
    task automatic random_item();
        logic [7:0]  unit_id;
        logic [7:0]  fc;
        int          base;
        int          n;
        int          offs;
        int          qty;
        int          pick;
        logic [15:0] qv;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            send_item(($urandom_range(0, 1) == 1) ? OP_LOAD_IREG : OP_LOAD_HREG,
                      8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      {$urandom, $urandom}, 4'($urandom), 16'($urandom));
            return;
        end
        unit_id = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        fc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
        case (fc)
            FC_READ_COILS:   begin base = resp_sb.bases[CFG_COIL_BASE];   n = 64; end
            FC_READ_DINPUTS: begin base = resp_sb.bases[CFG_DINPUT_BASE]; n = 64; end
            FC_READ_HREGS:   begin base = resp_sb.bases[CFG_HREG_BASE];   n = 16; end
            FC_READ_IREGS:   begin base = resp_sb.bases[CFG_IREG_BASE];   n = 16; end
            default:         begin base = resp_sb.bases[CFG_COIL_BASE];   n = 64; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 80)
            offs = $urandom_range(0, n - 1);
        else if (pick < 90)
            offs = int'($urandom_range(0, 4)) - 2 + ((pick % 2 == 0) ? 0 : n);
        else
            offs = int'($urandom_range(0, 65535)) - base;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            qty = $urandom_range(1, (n - offs > 0 && n - offs <= n) ? n - offs : 1);
        else if (pick < 90)
            qty = (pick % 2 == 0) ? 0 : n - offs + 1;
        else
            qty = $urandom_range(0, 65535);
        qv = 16'(qty);
        if (fc == FC_WRITE_COIL)
        begin
            pick = $urandom_range(0, 9);
            qv = (pick < 5) ? COIL_ON : (pick < 9) ? COIL_OFF : 16'($urandom);
        end
        send_request(unit_id, fc, 16'(base + offs), qv, {$urandom, $urandom});
    endtask

    initial
    begin
        #4_000_000;
        $display("modbus_rtu_slave_responder_top test failed");
        $finish;
    end

    initial
    begin
        logic [15:0] phase_bases [4][4];
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_REQUEST;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_COIL_BASE;
        cfg_data = '0;
        mismatches = 0;
        burst_left = 1;
        stall_mode = 0;
        stall_count = 0;
        resp_sb = new();
        phase_bases = '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000},
                        '{16'hFFFF, 16'hFFC0, 16'hFFF0, 16'hFFFF},
                        '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                        '{16'd1000, 16'd5, 16'h8000, 16'd40}};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every register entry so that no read ever hits an unwritten one.
        for (int i = 0; i < 16; i++)
        begin
            send_item(OP_LOAD_HREG, 8'd0, 8'd0, 16'd0, 16'd0, 64'd0, 4'(i), 16'($urandom));
            send_item(OP_LOAD_IREG, 8'd0, 8'd0, 16'd0, 16'd0, 64'd0, 4'(i), 16'($urandom));
        end

        // Directed requests with all bases at zero.
        send_request(8'd1, FC_WRITE_COIL, 16'd0, COIL_ON, 64'd0);
        send_request(8'd255, FC_WRITE_COIL, 16'd63, COIL_ON, 64'd0);
        send_request(8'd7, FC_WRITE_COIL, 16'd64, COIL_ON, 64'd0);
        send_request(8'd7, FC_WRITE_COIL, 16'd5, 16'h1234, 64'd0);
        send_request(8'd7, FC_WRITE_COIL, 16'd65535, 16'hFFFF, 64'd0);
        send_request(8'd0, FC_WRITE_COIL, 16'd9, COIL_ON, 64'd0);
        send_request(8'd3, FC_WRITE_COIL, 16'd63, COIL_OFF, 64'd0);
        send_request(8'd3, FC_READ_COILS, 16'd0, 16'd1, 64'd0);
        send_request(8'd3, FC_READ_COILS, 16'd0, 16'd64, 64'd0);
        send_request(8'd3, FC_READ_COILS, 16'd0, 16'd0, 64'd0);
        send_request(8'd3, FC_READ_COILS, 16'd0, LIMIT_BITS + 16'd1, 64'd0);
        send_request(8'd3, FC_READ_COILS, 16'd65535, 16'd1, 64'd0);
        send_request(8'd9, FC_READ_DINPUTS, 16'd0, 16'd64, '1);
        send_request(8'd9, FC_READ_DINPUTS, 16'd3, 16'd13, 64'hA5A5_0F0F_3C3C_F00F);
        send_request(8'd0, FC_READ_DINPUTS, 16'd70, 16'd1, 64'd0);
        send_request(8'd9, FC_READ_HREGS, 16'd0, 16'd16, 64'd0);
        send_request(8'd9, FC_READ_HREGS, 16'd0, LIMIT_REGS + 16'd1, 64'd0);
        send_request(8'd9, FC_READ_HREGS, 16'd15, 16'd2, 64'd0);
        send_request(8'd9, FC_READ_IREGS, 16'd15, 16'd1, 64'd0);
        send_request(8'd9, FC_READ_IREGS, 16'd0, 16'hFFFF, 64'd0);
        send_request(8'd9, 8'd0, 16'd0, 16'd1, 64'd0);
        send_request(8'd9, 8'd255, 16'hFFFF, 16'hFFFF, '1);
        send_item(OP_IGNORED, 8'd9, FC_READ_COILS, 16'd0, 16'd1, 64'd0, 4'd0, 16'd0);

        // Random phases, each under its own set of bases.
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            for (int r = 0; r < 4; r++)
                write_reg(2'(r), phase_bases[p][r]);
            for (int k = 0; k < 26; k++)
                random_item();
        end

        wait_idle();
        if (mismatches == 0)
            $display("modbus_rtu_slave_responder_top test passed");
        else
            $display("modbus_rtu_slave_responder_top test failed");
        $finish;
    end
endmodule

FILE: modbus_rtu_slave_responder_top.f
src/mrsr_pkg.sv
src/mrsr_ctrl.sv
src/mrsr_dp.sv
src/modbus_rtu_slave_responder_top.sv
test/testbench.sv
